[sv/tps_pkg.sv]
// shared types, register codes and character class functions for the text pattern search unit
// depends on nothing; every other file of the unit imports it
package tps_pkg;

    localparam int PATTERN_SLOTS   = 12;
    localparam int PAT_CHAR_BITS   = 16;
    localparam int TEXT_CHAR_BITS  = 16;
    localparam int OUT_OFFSET_BITS = 32;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 64;
    localparam int CLASS_BITS      = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_WORD_A  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_WORD_B  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_WORD_C  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CASE_SENSITIVE  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WHOLE_WORD_ONLY = 3'd5;

    typedef logic [OUT_OFFSET_BITS-1:0] t_offset;

    typedef struct packed {
        logic [TEXT_CHAR_BITS-1:0] text_char;
        logic                      first_item;
        logic                      last_item;
        logic                      context_only;
    } t_in_word;

    typedef struct packed {
        logic    found;
        t_offset match_offset;
    } t_out_word;

    typedef struct packed {
        logic [PATTERN_SLOTS-1:0][PAT_CHAR_BITS-1:0] pattern;
        logic [3:0]                                  pattern_length;
        logic                                        case_sensitive;
        logic                                        whole_word_only;
    } t_cfg;

    // per-alignment verdicts handed from the checker to the control stage
    typedef struct packed {
        logic body_newest;   // pattern ends at the newest char
        logic body_prev;     // pattern ends one char before the newest
        logic start_newest;
        logic start_prev;
        logic bnd_newest;    // newest char is a boundary
        logic bnd_prev;
    } t_align;

    function automatic logic is_boundary(input logic [CLASS_BITS-1:0] c);
        logic r;
        r = 1'b0;
        if (c < 32'd128) begin
            r = (c == 32'd32) || (c >= 32'd9 && c <= 32'd13) ||
                (c >= 32'd33 && c <= 32'd47) || (c >= 32'd58 && c <= 32'd64) ||
                (c >= 32'd91 && c <= 32'd96) || (c >= 32'd123 && c <= 32'd126);
        end
        return r;
    endfunction

    function automatic logic is_alpha(input logic [CLASS_BITS-1:0] c);
        return (c >= 32'd65 && c <= 32'd90) || (c >= 32'd97 && c <= 32'd122);
    endfunction

    function automatic logic [CLASS_BITS-1:0] fold(input logic [CLASS_BITS-1:0] c);
        return (c >= 32'd65 && c <= 32'd90) ? c + 32'd32 : c;
    endfunction

    function automatic logic chars_equal(input logic [CLASS_BITS-1:0] t,
                                         input logic [CLASS_BITS-1:0] p,
                                         input logic                  cs);
        return (t == p) ||
               (!cs && is_alpha(t) && is_alpha(p) && (fold(t) == fold(p)));
    endfunction

endpackage

[sv/text_pattern_search_unit.sv]
// top level of the text pattern search unit: input register, window state, result register
// depends on tps_pkg, tps_cfg_regs and tps_align_check
//
// usage
//   input channel: one text word per handshake (i_in_valid high, o_in_stall low).
//   first_item starts a new search, last_item closes it, context_only marks a
//   neighbour char that may border a match but never belongs to one.
//   output channel: at most one word per search, found=1 with the start offset
//   counted in in-range chars, or found=0 when the search closed without a match.
//   words that arrive after the result are swallowed until the next first_item.
//   config channel: i_cfg_valid/o_cfg_ready, ready is always high; write only
//   while the unit is idle.
// timing
//   the word lands in the input register, then one pass of parallel window
//   compares writes the result register.
//   throughput is one word per cycle while no result waits under i_out_stall,
//   set by the single compare pass that updates the window state per word.
// reset and stall
//   synchronous active-low reset empties both registers, clears the window fill,
//   the offset and the finished flag, and loads the register defaults.
//   while a result waits under i_out_stall the input register still takes one
//   more word; after that o_in_stall rises until the result is taken.
module text_pattern_search_unit import tps_pkg::*; #(
    parameter int PATTERN_MAX = 12,
    parameter int CHAR_BITS   = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_word                  i_in_word,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_word                 o_out_word,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int WIN_DEPTH = PATTERN_MAX + 2;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

    // configuration
    t_cfg cfg;

    tps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_cfg_ready = 1'b1;

    // input register
    logic     r_in_valid;
    t_in_word r_in;
    logic     in_accept;
    logic     advance;     // result register can take a new value this cycle
    logic     process;     // the held word is worked on this cycle

    assign advance    = !o_out_valid || !i_out_stall;
    assign process    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
    end

    // search state: window of recent chars, fill count, offset, finished flag
    logic [WIN_DEPTH-1:0][CHAR_BITS-1:0] r_win_char;
    logic [WIN_DEPTH-1:0]                r_win_inr;
    logic [FILL_W-1:0]                   r_fill;
    logic [OFFSET_BITS-1:0]              r_off;
    logic                                r_fin;

    logic [WIN_DEPTH-1:0][CHAR_BITS-1:0] n_win_char;
    logic [WIN_DEPTH-1:0]                n_win_inr;
    logic [FILL_W-1:0]                   n_fill;
    logic [OFFSET_BITS-1:0]              n_off;
    logic                                n_fin;

    // a first word restarts from an empty window; stale entries beyond the
    // fill count are never looked at, so the chars themselves stay as they are
    logic [FILL_W-1:0]      base_fill;
    logic [OFFSET_BITS-1:0] base_off;
    logic                   base_fin;
    logic                   inr;

    assign base_fill = r_in.first_item ? '0 : r_fill;
    assign base_off  = r_in.first_item ? '0 : r_off;
    assign base_fin  = r_in.first_item ? 1'b0 : r_fin;
    assign inr       = !r_in.context_only;

    assign n_win_char = {r_win_char[WIN_DEPTH-2:0], CHAR_BITS'(r_in.text_char)};
    assign n_win_inr  = {r_win_inr[WIN_DEPTH-2:0], inr};
    assign n_fill     = (int'(base_fill) < WIN_DEPTH) ? base_fill + FILL_W'(1) : base_fill;
    assign n_off      = (inr && (base_off != '1)) ? base_off + OFFSET_BITS'(1) : base_off;

    // alignment compares on the shifted window
    t_align            align;
    logic [FILL_W-1:0] len;

    tps_align_check #(
        .PATTERN_MAX (PATTERN_MAX),
        .CHAR_BITS   (CHAR_BITS)
    ) u_align (
        .i_win_char (n_win_char),
        .i_win_inr  (n_win_inr),
        .i_fill     (n_fill),
        .i_cfg      (cfg),
        .o_len      (len),
        .o_align    (align)
    );

    // a match ending one char back needed its follower to prove the end boundary
    logic                   hit_prev;
    logic                   hit_newest;
    logic                   res;
    logic [OFFSET_BITS-1:0] back;
    logic [OFFSET_BITS-1:0] rep_off;

    assign hit_prev   = cfg.whole_word_only && align.body_prev && align.start_prev &&
                        !align.bnd_prev && align.bnd_newest;
    assign hit_newest = align.body_newest &&
                        (!cfg.whole_word_only ||
                         (align.start_newest && (align.bnd_newest || r_in.last_item)));
    assign res        = hit_prev || hit_newest || r_in.last_item;
    assign n_fin      = res;

    assign back    = hit_prev ? OFFSET_BITS'(len) + OFFSET_BITS'(inr) : OFFSET_BITS'(len);
    // once the offset counter saturates every match report reads all ones
    assign rep_off = (n_off == '1) ? n_off : n_off - back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_off  <= '0;
            r_fin  <= 1'b0;
        end else if (process) begin
            if (base_fin) begin
                r_fill <= base_fill;
                r_off  <= base_off;
                r_fin  <= base_fin;
            end else begin
                r_fill <= n_fill;
                r_off  <= n_off;
                r_fin  <= n_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && !base_fin) begin
            r_win_char <= n_win_char;
            r_win_inr  <= n_win_inr;
        end
    end

    // result register
    logic      r_out_valid;
    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && !base_fin && res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && !base_fin && res) begin
            r_out.found        <= hit_prev || hit_newest;
            r_out.match_offset <= (hit_prev || hit_newest) ? t_offset'(rep_off) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // checks
    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_result_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && !base_fin && res) |=> (r_fin && r_out_valid))
        else $error("result written without closing the search");

    a_miss_has_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.found) |-> (o_out_word.match_offset == '0))
        else $error("no-match result carries an offset");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= WIN_DEPTH)
        else $error("window fill count beyond the window depth");

endmodule

[sv/tps_cfg_regs.sv]
// configuration register file of the text pattern search unit
// depends on tps_pkg
module tps_cfg_regs import tps_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output t_cfg                      o_cfg
);

    logic [PATTERN_SLOTS-1:0][PAT_CHAR_BITS-1:0] r_pattern;
    logic [3:0]                                  r_pattern_length;
    logic                                        r_case_sensitive;
    logic                                        r_whole_word_only;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern         <= '0;
            r_pattern_length  <= 4'd1;
            r_case_sensitive  <= 1'b1;
            r_whole_word_only <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_WORD_A:  r_pattern[3:0]    <= i_cfg_data;
                CFG_PATTERN_WORD_B:  r_pattern[7:4]    <= i_cfg_data;
                CFG_PATTERN_WORD_C:  r_pattern[11:8]   <= i_cfg_data;
                CFG_PATTERN_LENGTH:  r_pattern_length  <= i_cfg_data[3:0];
                CFG_CASE_SENSITIVE:  r_case_sensitive  <= i_cfg_data[0];
                CFG_WHOLE_WORD_ONLY: r_whole_word_only <= i_cfg_data[0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg.pattern         = r_pattern;
    assign o_cfg.pattern_length  = r_pattern_length;
    assign o_cfg.case_sensitive  = r_case_sensitive;
    assign o_cfg.whole_word_only = r_whole_word_only;

endmodule

[sv/tps_align_check.sv]
// parallel compare of the pattern against the two decidable window alignments
// depends on tps_pkg
module tps_align_check import tps_pkg::*; #(
    parameter int PATTERN_MAX = 12,
    parameter int CHAR_BITS   = 16
) (
    input  logic [PATTERN_MAX+1:0][CHAR_BITS-1:0]      i_win_char,
    input  logic [PATTERN_MAX+1:0]                     i_win_inr,
    input  logic [$clog2(PATTERN_MAX+3)-1:0]           i_fill,
    input  t_cfg                                       i_cfg,
    output logic [$clog2(PATTERN_MAX+3)-1:0]           o_len,
    output t_align                                     o_align
);

    localparam int WIN_DEPTH = PATTERN_MAX + 2;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int IDX_W     = $clog2(WIN_DEPTH);

    logic [FILL_W-1:0]      len;
    logic [PATTERN_MAX-1:0] eq_newest;
    logic [PATTERN_MAX-1:0] eq_prev;
    logic [IDX_W-1:0]       idx_s0;
    logic [IDX_W-1:0]       idx_s1;
    logic [IDX_W-1:0]       idx_s2;

    // zero length means one, long lengths clip to PATTERN_MAX
    always_comb begin
        if (i_cfg.pattern_length == 4'd0) begin
            len = FILL_W'(1);
        end else if (int'(i_cfg.pattern_length) > PATTERN_MAX) begin
            len = FILL_W'(PATTERN_MAX);
        end else begin
            len = FILL_W'(i_cfg.pattern_length);
        end
    end

    for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_pos
        logic             active;
        logic [IDX_W-1:0] k_newest;
        logic [IDX_W-1:0] k_prev;

        assign active   = (FILL_W'(gi) < len);
        assign k_newest = active ? IDX_W'(len - FILL_W'(1) - FILL_W'(gi)) : '0;
        assign k_prev   = active ? IDX_W'(len - FILL_W'(gi)) : '0;

        assign eq_newest[gi] = !active ||
            (i_win_inr[k_newest] &&
             chars_equal(CLASS_BITS'(i_win_char[k_newest]),
                         CLASS_BITS'(i_cfg.pattern[gi]), i_cfg.case_sensitive));
        assign eq_prev[gi] = !active ||
            (i_win_inr[k_prev] &&
             chars_equal(CLASS_BITS'(i_win_char[k_prev]),
                         CLASS_BITS'(i_cfg.pattern[gi]), i_cfg.case_sensitive));
    end

    // match start sits at len-1 (newest alignment) or len (previous alignment)
    assign idx_s0 = IDX_W'(len - FILL_W'(1));
    assign idx_s1 = IDX_W'(len);
    assign idx_s2 = IDX_W'(len + FILL_W'(1));

    assign o_align.body_newest  = (i_fill >= len) && (&eq_newest);
    assign o_align.body_prev    = (i_fill >= len + FILL_W'(1)) && (&eq_prev);
    assign o_align.start_newest = is_boundary(CLASS_BITS'(i_win_char[idx_s0])) ||
                                  (i_fill <= len) ||
                                  is_boundary(CLASS_BITS'(i_win_char[idx_s1]));
    assign o_align.start_prev   = is_boundary(CLASS_BITS'(i_win_char[idx_s1])) ||
                                  (i_fill <= len + FILL_W'(1)) ||
                                  is_boundary(CLASS_BITS'(i_win_char[idx_s2]));
    assign o_align.bnd_newest   = is_boundary(CLASS_BITS'(i_win_char[0]));
    assign o_align.bnd_prev     = is_boundary(CLASS_BITS'(i_win_char[1]));

    assign o_len = len;

endmodule

[sim/tb_text_pattern_search_unit.sv]
// self-checking bench for text_pattern_search_unit: directed and random text words
// depends on tps_pkg and the unit's rtl; a scoreboard class predicts every result word
`timescale 1ns / 100ps

// holds the search settings and the char window, predicts the verdict of each
// accepted text word and compares the unit's result words in order
class search_tracker;
    logic [15:0] pat [12];
    logic [3:0]  plen;
    bit          cs;
    bit          ww;
    logic [15:0] win_c [14];
    bit          win_in [14];
    int          fill;
    logic [31:0] offs;
    bit          done;
    tps_pkg::t_out_word verdicts_due [$];
    int          errors;
    int          searched;
    int          hit_words;
    int          misses;

    function new();
        foreach (pat[i]) pat[i] = '0;
        plen = 4'd1;
        cs = 1'b1;
        ww = 1'b0;
        clear_window();
        errors = 0;
        searched = 0;
        hit_words = 0;
        misses = 0;
    endfunction

    function void clear_window();
        foreach (win_c[i]) begin
            win_c[i] = '0;
            win_in[i] = 1'b0;
        end
        fill = 0;
        offs = '0;
        done = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] d);
        case (idx)
            tps_pkg::CFG_PATTERN_WORD_A: for (int i = 0; i < 4; i++) pat[i] = d[16*i +: 16];
            tps_pkg::CFG_PATTERN_WORD_B: for (int i = 0; i < 4; i++) pat[4+i] = d[16*i +: 16];
            tps_pkg::CFG_PATTERN_WORD_C: for (int i = 0; i < 4; i++) pat[8+i] = d[16*i +: 16];
            tps_pkg::CFG_PATTERN_LENGTH: plen = d[3:0];
            tps_pkg::CFG_CASE_SENSITIVE: cs = d[0];
            tps_pkg::CFG_WHOLE_WORD_ONLY: ww = d[0];
            default: ;
        endcase
    endfunction

    // length zero acts as one, anything past the slot count clips to it
    function int span();
        if (plen == 4'd0) return 1;
        if (int'(plen) > tps_pkg::PATTERN_SLOTS) return tps_pkg::PATTERN_SLOTS;
        return int'(plen);
    endfunction

    function bit gap_char(logic [15:0] c);
        if (c > 16'd126) return 1'b0;
        if (c == 16'd32 || (c >= 16'd9 && c <= 16'd13)) return 1'b1;
        return (c >= 16'd33 && c <= 16'd47) || (c >= 16'd58 && c <= 16'd64) ||
               (c >= 16'd91 && c <= 16'd96) || (c >= 16'd123);
    endfunction

    function bit letter(logic [15:0] c);
        return (c >= 16'd65 && c <= 16'd90) || (c >= 16'd97 && c <= 16'd122);
    endfunction

    function bit same_char(logic [15:0] t, logic [15:0] p);
        if (t == p) return 1'b1;
        return !cs && letter(t) && letter(p) && ((t | 16'h20) == (p | 16'h20));
    endfunction

    // pattern laid over the window with its last char at index e (0 = newest)
    function bit body_hits(int e, int len);
        int k;
        if (fill < e + len) return 1'b0;
        for (int i = 0; i < len; i++) begin
            k = e + len - 1 - i;
            if (!win_in[k] || !same_char(win_c[k], pat[i])) return 1'b0;
        end
        return 1'b1;
    endfunction

    function bit opens_word(int e, int len);
        int s;
        s = e + len - 1;
        if (gap_char(win_c[s])) return 1'b1;
        if (fill <= s + 1) return 1'b1;
        return gap_char(win_c[s+1]);
    endfunction

    function logic [31:0] start_of(int back);
        if (offs == '1) return '1;
        return offs - 32'(back);
    endfunction

    function void push_verdict(bit hit, logic [31:0] at);
        tps_pkg::t_out_word v;
        v.found = hit;
        v.match_offset = at;
        verdicts_due = {verdicts_due, v};
        done = 1'b1;
    endfunction

    // one accepted text word
    function void note_word(tps_pkg::t_in_word w);
        bit inr;
        int len;
        inr = !w.context_only;
        len = span();
        searched++;
        if (w.first_item) clear_window();
        if (done) return;
        for (int k = 13; k > 0; k--) begin
            win_c[k] = win_c[k-1];
            win_in[k] = win_in[k-1];
        end
        win_c[0] = w.text_char;
        win_in[0] = inr;
        if (fill < 14) fill++;
        if (inr && offs != '1) offs++;
        // match that ended one char back and waited for its follower
        if (ww && body_hits(1, len) && opens_word(1, len) &&
            !gap_char(win_c[1]) && gap_char(win_c[0])) begin
            push_verdict(1'b1, start_of(len + (inr ? 1 : 0)));
        end else if (body_hits(0, len) &&
                     (!ww || (opens_word(0, len) && (gap_char(win_c[0]) || w.last_item)))) begin
            push_verdict(1'b1, start_of(len));
        end else if (w.last_item) begin
            push_verdict(1'b0, '0);
        end
    endfunction

    function void check_word(tps_pkg::t_out_word got);
        tps_pkg::t_out_word want;
        if (verdicts_due.size() == 0) begin
            $error("result word with nothing expected: found %0d, match_offset %0d",
                   got.found, got.match_offset);
            errors++;
            return;
        end
        want = verdicts_due.pop_front();
        if (want.found) hit_words++;
        else misses++;
        if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            errors++;
        end
        if (got.match_offset !== want.match_offset) begin
            $error("match_offset: expected %0d, actual %0d", want.match_offset,
                   got.match_offset);
            errors++;
        end
    endfunction

    function int owed();
        return verdicts_due.size();
    endfunction
endclass

module tb_text_pattern_search_unit;
    import tps_pkg::*;

    localparam int RANDOM_WORDS  = 1900;
    localparam int HOLD_CYCLES   = 120;   // long receiver hold-off, fills the unit
    localparam int SETTLE_CYCLES = 4;     // margin for the input and result registers to drain
    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake of any kind

    // boundary chars at the edges of every punctuation range
    localparam logic [15:0] GAP_CHARS [12] = '{16'd9, 16'd10, 16'd13, 16'd32, 16'd33,
        16'd47, 16'd58, 16'd64, 16'd91, 16'd96, 16'd123, 16'd126};
    // non-boundary chars near those edges, the code extremes, plus letters shifted out of ascii
    localparam logic [15:0] ODD_CHARS [12] = '{16'd0, 16'd8, 16'd14, 16'd31, 16'd48,
        16'd57, 16'd127, 16'd128, 16'h0141, 16'h0161, 16'hFF41, 16'hFFFF};

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    search_tracker tracker = new();

    // idling switches, flipped per phase so that some stretches run flat out
    bit in_idle = 1'b0;
    bit out_idle = 1'b0;
    int hold_cycles = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int settings_run = 0;

    text_pattern_search_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side: stall drawn per result word, long hold-off counted here
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_stall = 1'b1;
            hold_cycles--;
        end else if (stall_left > 0) begin
            out_stall = 1'b1;
            stall_left--;
        end else begin
            out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            tracker.check_word(out_word);
            stall_left = out_idle ? $urandom_range(0, 8) : 0;
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [15:0] pick_gap();
        return GAP_CHARS[$urandom_range(0, 11)];
    endfunction

    // mostly a small letter set so that random text hits the pattern often
    function automatic logic [15:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return ($urandom_range(0, 1) ? 16'h41 : 16'h61) + 16'($urandom_range(0, 2));
        if (r < 65) return pick_gap();
        if (r < 75) return ODD_CHARS[$urandom_range(0, 11)];
        if (r < 85) return 16'h30 + 16'($urandom_range(0, 9));
        if (r < 95) return ($urandom_range(0, 1) ? 16'h41 : 16'h61) + 16'($urandom_range(0, 25));
        return 16'($urandom);
    endfunction

    // flip the case of an ascii letter now and then, often when case is folded
    function automatic logic [15:0] recase(logic [15:0] c);
        if (!tracker.letter(c)) return c;
        if ($urandom_range(0, 9) < (tracker.cs ? 1 : 5)) return c ^ 16'h20;
        return c;
    endfunction

    function automatic t_in_word mk(logic [15:0] c, bit first, bit last, bit ctx);
        t_in_word w;
        w.text_char = c;
        w.first_item = first;
        w.last_item = last;
        w.context_only = ctx;
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        gap = in_idle ? $urandom_range(0, 8) : 0;
        @(negedge i_clk);
        repeat (gap) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_word = w;
        do @(posedge i_clk); while (in_stall);
        tracker.note_word(w);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        do @(posedge i_clk); while (!cfg_ready);
        tracker.set_reg(idx, d);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // sender pauses until every expected result word is back, then lets the
    // pipeline empty of words that cause none
    task automatic settle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (tracker.owed() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_setup(logic [63:0] wa, logic [63:0] wb, logic [63:0] wc,
                              logic [63:0] len, logic [63:0] cs, logic [63:0] ww);
        write_reg(CFG_PATTERN_WORD_A, wa);
        write_reg(CFG_PATTERN_WORD_B, wb);
        write_reg(CFG_PATTERN_WORD_C, wc);
        write_reg(CFG_PATTERN_LENGTH, len);
        write_reg(CFG_CASE_SENSITIVE, cs);
        write_reg(CFG_WHOLE_WORD_ONLY, ww);
        settings_run++;
    endtask

    // first few phases pin the length extremes, later ones draw freely;
    // upper data bits carry junk the registers must drop
    task automatic random_setup(int phase);
        logic [15:0] pc [12];
        logic [63:0] wa, wb, wc, lenv, csv, wwv;
        int r, len;
        foreach (pc[i]) pc[i] = pick_char();
        wa = {pc[3], pc[2], pc[1], pc[0]};
        wb = {pc[7], pc[6], pc[5], pc[4]};
        wc = {pc[11], pc[10], pc[9], pc[8]};
        r = $urandom_range(0, 9);
        if (r == 0) begin
            wa = '1;
            wb = '1;
            wc = '1;
        end else if (r == 1) begin
            wa = {$urandom, $urandom};
            wb = {$urandom, $urandom};
            wc = {$urandom, $urandom};
        end
        r = $urandom_range(0, 9);
        case (phase)
            0: len = 12;
            1: len = 1;
            2: len = 15;
            3: len = 0;
            default: len = (r < 5) ? $urandom_range(1, 4) : (r < 8) ? $urandom_range(5, 12) :
                           (r == 8) ? $urandom_range(13, 15) : 0;
        endcase
        lenv = {$urandom, $urandom};
        lenv[3:0] = 4'(len);
        csv = {$urandom, $urandom};
        wwv = {$urandom, $urandom};
        if (phase == 0) begin
            csv[0] = 1'b0;
            wwv[0] = 1'b1;
        end
        load_setup(wa, wb, wc, lenv, csv, wwv);
    endtask

    // well-formed search: optional leading neighbour, text with the pattern
    // often planted inside, optional trailing neighbour
    task automatic send_search();
        logic [15:0] txt [$];
        bit          ctx [$];
        t_in_word    w;
        int          len, n, at, lead;
        len = tracker.span();
        lead = ($urandom_range(0, 3) == 0) ? 1 : 0;
        n = $urandom_range(1, len + 8);
        repeat (lead) begin
            txt = {txt, pick_char()};
            ctx = {ctx, 1'b1};
        end
        repeat (n) begin
            txt = {txt, pick_char()};
            ctx = {ctx, 1'b0};
        end
        if (n >= len && $urandom_range(0, 9) < 7) begin
            at = lead + $urandom_range(0, n - len);
            for (int i = 0; i < len; i++) txt[at+i] = recase(tracker.pat[i]);
            if (at > 0 && $urandom_range(0, 1)) txt[at-1] = pick_gap();
            if (at + len < txt.size() && $urandom_range(0, 1)) txt[at+len] = pick_gap();
        end
        // a neighbour char inside the range breaks any match over it
        if ($urandom_range(0, 19) == 0) ctx[lead + $urandom_range(0, n - 1)] = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
            txt = {txt, pick_char()};
            ctx = {ctx, 1'b1};
        end
        for (int i = 0; i < txt.size(); i++) begin
            w = mk(txt[i], (i == 0) && ($urandom_range(0, 19) != 0),
                   (i == txt.size() - 1) && ($urandom_range(0, 9) != 0), ctx[i]);
            send_word(w);
        end
    endtask

    // short burst of words with every bit drawn at random
    task automatic send_noise();
        logic [31:0] r;
        t_in_word    w;
        repeat ($urandom_range(1, 6)) begin
            r = $urandom;
            w = r[$bits(t_in_word)-1:0];
            send_word(w);
        end
    endtask

    initial begin : stimulus
        int phase;
        int searches;
        int target;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pattern "aB", case folded, whole words only
        load_setup(64'h0000_0000_0042_0061, 64'h0, 64'h0, 64'd2, 64'd0, 64'd1);
        // leading neighbour is a space, range ends on a space
        send_word(mk(16'h20, 1, 0, 1));
        send_word(mk(16'h61, 0, 0, 0));
        send_word(mk(16'h42, 0, 0, 0));
        send_word(mk(16'h20, 0, 1, 0));
        // match closed by the end of the text
        send_word(mk(16'h61, 1, 0, 0));
        send_word(mk(16'h62, 0, 1, 0));
        // last word is a neighbour letter, so the word goes on
        send_word(mk(16'h41, 1, 0, 0));
        send_word(mk(16'h62, 0, 0, 0));
        send_word(mk(16'h63, 0, 1, 1));
        // neighbour inside the range splits the pattern
        send_word(mk(16'h61, 1, 0, 0));
        send_word(mk(16'h3F, 0, 0, 1));
        send_word(mk(16'h62, 0, 1, 0));
        // top char code alone
        send_word(mk(16'hFFFF, 1, 1, 0));
        // words after the match are swallowed until the next first word
        send_word(mk(16'h20, 1, 0, 0));
        send_word(mk(16'h61, 0, 0, 0));
        send_word(mk(16'h62, 0, 0, 0));
        send_word(mk(16'h21, 0, 0, 0));
        send_word(mk(16'h7A, 0, 0, 0));
        send_word(mk(16'h71, 0, 1, 0));
        settle();

        // zero length acts as one; pattern char all ones, exact compare
        load_setup('1, 64'h0, 64'h0, 64'd0, 64'd1, 64'd0);
        send_word(mk(16'h78, 1, 0, 0));
        send_word(mk(16'hFFFF, 0, 0, 0));
        send_word(mk(16'h79, 0, 1, 0));
        settle();

        // length past the slot count clips to twelve
        load_setup(64'h0, 64'h0, 64'h0, 64'd13, 64'd0, 64'd1);
        send_word(mk(16'h0000, 1, 1, 0));
        settle();

        target = tracker.searched + RANDOM_WORDS;
        phase = 0;
        while (tracker.searched < target) begin
            random_setup(phase);
            in_idle = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            searches = $urandom_range(8, 24);
            if (phase == 1) begin
                // sender keeps offering while the result side holds off
                in_idle = 1'b0;
                hold_cycles = HOLD_CYCLES;
            end
            repeat (searches) begin
                if ($urandom_range(0, 6) == 0) send_noise();
                else send_search();
            end
            settle();
            phase++;
        end

        $display("covered %0d text words under %0d register settings",
                 tracker.searched, settings_run);
        $display("checked %0d match and %0d no-match result words",
                 tracker.hit_words, tracker.misses);
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
